// ===== rtl/fir_row_filter_clamped_edges_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the horizontal FIR row filter
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIR_ROW_FILTER_CLAMPED_EDGES_MACROS_SVH
`define FIR_ROW_FILTER_CLAMPED_EDGES_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FRCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/frce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR row filter package
// Shared constants, register indexes and the pipeline control struct.
// ----------------------------------------------------------------------------
package frce_pkg;

  // Default values of the top-level parameters.
  localparam int DEF_MAX_ORDER    = 5;
  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int DEF_COEF_FRAC    = 15;

  // Coefficients are Q1.15; a negated coefficient needs one more bit.
  localparam int COEF_W = 16;
  localparam int TAP_W  = COEF_W + 1;

  // Products are summed in groups of this size before the final add.
  localparam int GRP_SIZE = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ORD_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_ORDER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ODD_SYM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BASE = 3'd2;

  // Control travelling with one result through the pipeline.
  typedef struct packed {
    logic valid;
    logic row_done;
  } stg_ctl_t;

endpackage

// ===== rtl/frce_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR row filter configuration registers
// Holds order, symmetry and half coefficients and expands them into one
// signed tap per window position.
// ----------------------------------------------------------------------------
module frce_cfg import frce_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  localparam int ORD_W = $clog2(MAX_ORDER + 1),
  localparam int WIN_DEPTH = 2 * MAX_ORDER + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic [ORD_W-1:0]             order,
  output logic signed [TAP_W-1:0]      taps [WIN_DEPTH]
);

  localparam int NUM_COEF = MAX_ORDER + 1;

  logic [CFG_ORD_W-1:0]       tap_order_r;
  logic                       odd_sym_r;
  logic signed [COEF_W-1:0]   coef_r [NUM_COEF];
  logic [CFG_IDX_W-1:0]       coef_sel;

  assign cfg_ready = 1'b1;
  assign coef_sel  = cfg_index - REG_COEF_BASE;

  // Register writes; coefficient indexes past the stored set are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_order_r <= CFG_ORD_W'(1);
      odd_sym_r   <= 1'b0;
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TAP_ORDER: begin
          tap_order_r <= cfg_data[CFG_ORD_W-1:0];
        end
        REG_ODD_SYM: begin
          odd_sym_r <= cfg_data[0];
        end
        default: begin
          if (cfg_index >= REG_COEF_BASE && coef_sel < CFG_IDX_W'(NUM_COEF)) begin
            coef_r[coef_sel[ORD_W-1:0]] <= cfg_data;
          end
        end
      endcase
    end
  end

  // An order above the supported maximum acts as the maximum.
  assign order = (tap_order_r > CFG_ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER)
                                                       : tap_order_r[ORD_W-1:0];

  // Window position i sees offset order - i. Positions at or left of the
  // center carry the negated coefficient in antisymmetric mode.
  always_comb begin
    logic [ORD_W:0]            lane;
    logic [ORD_W:0]            ord_x;
    logic [ORD_W:0]            mag_x;
    logic signed [TAP_W-1:0]   tap_h;
    ord_x = {1'b0, order};
    for (int i = 0; i < WIN_DEPTH; i++) begin
      lane  = (ORD_W + 1)'(i);
      mag_x = '0;
      tap_h = '0;
      if (lane > (ord_x << 1)) begin
        taps[i] = '0;
      end else begin
        if (lane <= ord_x) begin
          mag_x = ord_x - lane;
        end else begin
          mag_x = lane - ord_x;
        end
        tap_h   = TAP_W'(coef_r[mag_x[ORD_W-1:0]]);
        taps[i] = (odd_sym_r && lane <= ord_x) ? -tap_h : tap_h;
      end
    end
  end

endmodule

// ===== rtl/frce_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR row filter sample window and issue control
// Shifts samples into the window, replicates the left edge at row start and
// walks the right edge at row end, issuing one window per result.
// ----------------------------------------------------------------------------
`include "fir_row_filter_clamped_edges_macros.svh"

module frce_window import frce_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  localparam int ORD_W = $clog2(MAX_ORDER + 1),
  localparam int WIN_DEPTH = 2 * MAX_ORDER + 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_row_end,
  input  logic [ORD_W-1:0]               order,
  input  logic                           iss_ready,
  output stg_ctl_t                       iss_ctl,
  output logic signed [SAMPLE_WIDTH-1:0] win [WIN_DEPTH]
);

  logic signed [SAMPLE_WIDTH-1:0] win_r   [WIN_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] win_nxt [WIN_DEPTH];
  logic [ORD_W-1:0] row_cnt_r, row_cnt_nxt;
  logic             iss_valid_r, iss_valid_nxt;
  logic             iss_done_r, iss_done_nxt;
  logic             flush_r, flush_nxt;
  logic [ORD_W-1:0] pos_r, pos_nxt;
  logic [ORD_W-1:0] dstart_r, dstart_nxt;
  logic [ORD_W-1:0] pos_dec;
  logic             slot_free;
  logic             in_acc;
  logic             flush_step;

  // The issue slot empties when its window moves on to the multipliers.
  assign slot_free  = !iss_valid_r || iss_ready;
  assign in_ready   = !flush_r && slot_free;
  assign in_acc     = in_valid && in_ready;
  assign flush_step = flush_r && slot_free;
  assign pos_dec    = pos_r - ORD_W'(1);

  // Next window and issue state.
  always_comb begin
    win_nxt       = win_r;
    row_cnt_nxt   = row_cnt_r;
    iss_valid_nxt = slot_free ? 1'b0 : iss_valid_r;
    iss_done_nxt  = iss_done_r;
    flush_nxt     = flush_r;
    pos_nxt       = pos_r;
    dstart_nxt    = dstart_r;
    if (in_acc) begin
      // The first sample of a row fills the whole window.
      win_nxt[0] = in_sample;
      for (int i = 1; i < WIN_DEPTH; i++) begin
        win_nxt[i] = (row_cnt_r == '0) ? in_sample : win_r[i-1];
      end
      if (!in_row_end) begin
        iss_valid_nxt = (row_cnt_r >= order);
        iss_done_nxt  = 1'b0;
        if (row_cnt_r != ORD_W'(MAX_ORDER)) begin
          row_cnt_nxt = row_cnt_r + ORD_W'(1);
        end
      end else begin
        // Row end: emit pixels from distance dstart down to the last one.
        iss_valid_nxt = (row_cnt_r >= order);
        iss_done_nxt  = (order == '0);
        flush_nxt     = (order != '0);
        pos_nxt       = order;
        dstart_nxt    = (row_cnt_r >= order) ? order : row_cnt_r;
        row_cnt_nxt   = '0;
      end
    end else if (flush_step) begin
      // Shift in a copy of the newest sample to replicate the right edge.
      win_nxt[0] = win_r[0];
      for (int i = 1; i < WIN_DEPTH; i++) begin
        win_nxt[i] = win_r[i-1];
      end
      iss_valid_nxt = (pos_dec <= dstart_r);
      iss_done_nxt  = (pos_dec == '0);
      flush_nxt     = (pos_dec != '0);
      pos_nxt       = pos_dec;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r   <= '0;
      iss_valid_r <= 1'b0;
      iss_done_r  <= 1'b0;
      flush_r     <= 1'b0;
      pos_r       <= '0;
      dstart_r    <= '0;
    end else begin
      row_cnt_r   <= row_cnt_nxt;
      iss_valid_r <= iss_valid_nxt;
      iss_done_r  <= iss_done_nxt;
      flush_r     <= flush_nxt;
      pos_r       <= pos_nxt;
      dstart_r    <= dstart_nxt;
    end
  end

  // Sample window.
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign win     = win_r;
  assign iss_ctl = '{valid: iss_valid_r, row_done: iss_done_r};

  // A row end with a nonzero order starts the right-edge walk.
  `FRCE_ASSERT_NXT(a_flush_start, in_acc && in_row_end && (order != '0), flush_r,
    "row end did not start the edge walk")
  // The last walk step issues the final pixel of the row.
  `FRCE_ASSERT_NXT(a_flush_last, flush_step && (pos_r == ORD_W'(1)),
    !flush_r && iss_valid_r && iss_done_r, "edge walk ended without the row's final pixel")
  // The final pixel of a row is issued with the row count already cleared.
  `FRCE_ASSERT_IMP(a_done_cleared, iss_valid_r && iss_done_r, row_cnt_r == '0,
    "row count not cleared at row end")
  // The walk position never sits at zero while the walk is still running.
  `FRCE_ASSERT_IMP(a_flush_pos, flush_r, pos_r != '0,
    "edge walk running at position zero")

endmodule

// ===== rtl/frce_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR row filter multiply and partial sum stages
// One multiplier per window position, products registered, then summed in
// small groups into registered partial sums.
// ----------------------------------------------------------------------------
module frce_mac import frce_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  localparam int WIN_DEPTH = 2 * MAX_ORDER + 1,
  localparam int PROD_W = SAMPLE_WIDTH + TAP_W,
  localparam int NUM_GRP = (WIN_DEPTH + GRP_SIZE - 1) / GRP_SIZE,
  localparam int PSUM_W = PROD_W + $clog2(GRP_SIZE)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  stg_ctl_t                       iss_ctl,
  output logic                           iss_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] win [WIN_DEPTH],
  input  logic signed [TAP_W-1:0]        taps [WIN_DEPTH],
  output stg_ctl_t                       sum_ctl,
  input  logic                           sum_ready,
  output logic signed [PSUM_W-1:0]       psum [NUM_GRP]
);

  stg_ctl_t                  p_ctl_r;
  stg_ctl_t                  s_ctl_r;
  logic signed [PROD_W-1:0]  prod_r   [WIN_DEPTH];
  logic signed [PSUM_W-1:0]  psum_r   [NUM_GRP];
  logic signed [PSUM_W-1:0]  psum_nxt [NUM_GRP];
  logic                      p_ready;
  logic                      s_ready;

  assign p_ready   = !p_ctl_r.valid || s_ready;
  assign s_ready   = !s_ctl_r.valid || sum_ready;
  assign iss_ready = p_ready;

  // Stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_ctl_r <= '0;
      s_ctl_r <= '0;
    end else begin
      if (p_ready) begin
        p_ctl_r <= iss_ctl;
      end
      if (s_ready) begin
        s_ctl_r <= p_ctl_r;
      end
    end
  end

  // One product per window position.
  always_ff @(posedge clk) begin
    if (p_ready && iss_ctl.valid) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        prod_r[i] <= PROD_W'(win[i]) * PROD_W'(taps[i]);
      end
    end
  end

  // Group sums of the registered products.
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      psum_nxt[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (g * GRP_SIZE + j < WIN_DEPTH) begin
          psum_nxt[g] = psum_nxt[g] + PSUM_W'(prod_r[g*GRP_SIZE+j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && p_ctl_r.valid) begin
      psum_r <= psum_nxt;
    end
  end

  assign sum_ctl = s_ctl_r;
  assign psum    = psum_r;

endmodule

// ===== rtl/frce_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR row filter final sum, rounding and saturation
// Adds the partial sums with the rounding constant, then shifts out the
// fraction bits and saturates into the output register.
// ----------------------------------------------------------------------------
module frce_round import frce_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC = DEF_COEF_FRAC,
  localparam int WIN_DEPTH = 2 * MAX_ORDER + 1,
  localparam int NUM_GRP = (WIN_DEPTH + GRP_SIZE - 1) / GRP_SIZE,
  localparam int PSUM_W = SAMPLE_WIDTH + TAP_W + $clog2(GRP_SIZE)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  stg_ctl_t                       sum_ctl,
  output logic                           sum_ready,
  input  logic signed [PSUM_W-1:0]       psum [NUM_GRP],
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered,
  output logic                           out_row_done
);

  localparam int ACC_RAW = PSUM_W + $clog2(NUM_GRP) + 1;
  localparam int ACC_W   = (ACC_RAW > COEF_FRAC + 1) ? ACC_RAW : COEF_FRAC + 2;

  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  stg_ctl_t                        a_ctl_r;
  logic signed [ACC_W-1:0]         acc_r, acc_nxt;
  logic signed [ACC_W-1:0]         shifted;
  logic signed [SAMPLE_WIDTH-1:0]  sat_val;
  logic                            out_valid_r;
  logic                            out_done_r;
  logic signed [SAMPLE_WIDTH-1:0]  out_filt_r;
  logic                            a_ready;
  logic                            b_ready;

  assign b_ready   = !out_valid_r || out_ready;
  assign a_ready   = !a_ctl_r.valid || b_ready;
  assign sum_ready = a_ready;

  // Full sum plus one half LSB of the result.
  always_comb begin
    acc_nxt = RND;
    for (int g = 0; g < NUM_GRP; g++) begin
      acc_nxt = acc_nxt + ACC_W'(psum[g]);
    end
  end

  // Arithmetic shift floors, which with the half added rounds half up.
  assign shifted = acc_r >>> COEF_FRAC;

  always_comb begin
    if (shifted > SAT_HI) begin
      sat_val = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (shifted < SAT_LO) begin
      sat_val = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      sat_val = shifted[SAMPLE_WIDTH-1:0];
    end
  end

  // Stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_ctl_r <= sum_ctl;
      end
      if (b_ready) begin
        out_valid_r <= a_ctl_r.valid;
      end
    end
  end

  // Accumulator and output data.
  always_ff @(posedge clk) begin
    if (a_ready && sum_ctl.valid) begin
      acc_r <= acc_nxt;
    end
    if (b_ready && a_ctl_r.valid) begin
      out_filt_r <= sat_val;
      out_done_r <= a_ctl_r.row_done;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filt_r;
  assign out_row_done = out_done_r;

endmodule

// ===== rtl/fir_row_filter_clamped_edges.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Horizontal FIR row filter with replicated borders
// Filters each image row with symmetric or antisymmetric taps built from
// half coefficients, replicating the edge samples beyond both row ends.
//
//   Channel  Direction  Handshake               Payload
//   in_      slave      in_tvalid / in_tready   tdata: sample, tlast: row_end
//   out_     master     out_tvalid / out_tready tdata: filtered, tlast: row_done
//   cfg_     slave      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One sample is taken per cycle while in_tready is high. At row end the input holds
// for as many walk steps as the effective order (tap_order capped at MAX_ORDER)
// while the window is walked past the right edge, at most one result per step.
// After its issue a result passes the window, products, group sums, full sum and
// output registers in turn; throughput is set by the issue slot of the window.
// Synchronous rst_n clears control state, coefficients and symmetry; order is 1.
// A stalled out_tready fills the pipeline registers and then holds in_tready low.
// ----------------------------------------------------------------------------
module fir_row_filter_clamped_edges import frce_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int COEF_FRAC = DEF_COEF_FRAC,
  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,   // [SAMPLE_WIDTH-1:0] sample
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,  // [SAMPLE_WIDTH-1:0] filtered
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ORD_W     = $clog2(MAX_ORDER + 1);
  localparam int WIN_DEPTH = 2 * MAX_ORDER + 1;
  localparam int NUM_GRP   = (WIN_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PSUM_W    = SAMPLE_WIDTH + TAP_W + $clog2(GRP_SIZE);

  logic [ORD_W-1:0]               order;
  logic signed [TAP_W-1:0]        taps [WIN_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] win  [WIN_DEPTH];
  logic signed [PSUM_W-1:0]       psum [NUM_GRP];
  logic signed [SAMPLE_WIDTH-1:0] filtered;
  stg_ctl_t                       iss_ctl;
  stg_ctl_t                       sum_ctl;
  logic                           iss_ready;
  logic                           sum_ready;

  // Configuration registers and tap expansion.
  frce_cfg #(
    .MAX_ORDER (MAX_ORDER)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .order     (order),
    .taps      (taps)
  );

  // Sample window and issue control.
  frce_window #(
    .MAX_ORDER    (MAX_ORDER),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_sample  ($signed(in_tdata[SAMPLE_WIDTH-1:0])),
    .in_row_end (in_tlast),
    .order      (order),
    .iss_ready  (iss_ready),
    .iss_ctl    (iss_ctl),
    .win        (win)
  );

  // Products and group sums.
  frce_mac #(
    .MAX_ORDER    (MAX_ORDER),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .iss_ctl   (iss_ctl),
    .iss_ready (iss_ready),
    .win       (win),
    .taps      (taps),
    .sum_ctl   (sum_ctl),
    .sum_ready (sum_ready),
    .psum      (psum)
  );

  // Final sum, rounding, saturation and output register.
  frce_round #(
    .MAX_ORDER    (MAX_ORDER),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_FRAC    (COEF_FRAC)
  ) u_round (
    .clk          (clk),
    .rst_n        (rst_n),
    .sum_ctl      (sum_ctl),
    .sum_ready    (sum_ready),
    .psum         (psum),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_filtered (filtered),
    .out_row_done (out_tlast)
  );

  // Result data, zero filled up to whole bytes.
  assign out_tdata = TDATA_W'($unsigned(filtered));

endmodule
